### hw/rtl/mfbr_pkg.sv
// Shared types and constants of the MSB-first bit reader.
package mfbr_pkg;

    localparam int unsigned BUF_BYTES_DEF  = 4096;
    localparam int unsigned MAX_FIELD_BITS = 64;
    localparam int unsigned ACC_BITS       = MAX_FIELD_BITS + 8;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_PEEK   = 2'd1,
        OP_READ   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_DRAIN,
        S_DONE
    } t_state;

    // control from the sequencer to the field assembler
    typedef struct packed {
        logic       clr;
        logic       shift_en;
        logic [2:0] align;
        logic [6:0] count;
    } t_asm_ctl;

endpackage

### hw/rtl/mfbr_ram.sv
// Generic single-port RAM with registered read data.
module mfbr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/mfbr_asm.sv
// Field assembler: collects fetched bytes, aligns and masks the field.
module mfbr_asm
    import mfbr_pkg::*;
(
    input  logic                      i_clk,
    input  t_asm_ctl                  i_ctl,
    input  logic [7:0]                i_byte,
    output logic [MAX_FIELD_BITS-1:0] o_value
);

    logic [ACC_BITS-1:0]       r_acc;
    logic [ACC_BITS-1:0]       shifted;
    logic [MAX_FIELD_BITS-1:0] mask;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (i_ctl.shift_en) begin
            r_acc <= {r_acc[ACC_BITS-9:0], i_byte};
        end
    end

    // trailing bits of the last byte drop off; count bits are kept
    always_comb begin
        shifted = r_acc >> i_ctl.align;
        if (i_ctl.count >= 7'(MAX_FIELD_BITS)) begin
            mask = '1;
        end else begin
            mask = (MAX_FIELD_BITS'(1) << i_ctl.count) - MAX_FIELD_BITS'(1);
        end
        o_value = shifted[MAX_FIELD_BITS-1:0] & mask;
    end

endmodule

### hw/rtl/msb_first_bit_reader.sv
// Sequence: append and a failed, zero-bit or undefined request go from idle
//   to done and then to the output register; a field over n stored bytes (n = 1..9) is
//   fetched byte by byte through the single byte port of the buffer RAM, then drain and done.
// Throughput: one transaction at a time; the next is accepted as soon as the
//   previous result has moved to the output register, even if not yet taken.
// Reset: synchronous, active low; clears fill count, cursor and handshakes.
//   Buffer contents are not cleared, so there is no clearing pass.
module msb_first_bit_reader
    import mfbr_pkg::*;
#(
    parameter int unsigned BUF_BYTES = BUF_BYTES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // slave side
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [15:0]               i_s_tdata,   // byte_in[7:0], bit_count[14:8], pad
    input  logic [1:0]                i_s_tuser,   // operation[1:0]
    // master side
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [MAX_FIELD_BITS-1:0] o_m_tdata,   // field_value[63:0]
    output logic                      o_m_tuser    // status[0]
);

    localparam int unsigned AW = $clog2(BUF_BYTES);      // buffer address
    localparam int unsigned HW = $clog2(BUF_BYTES + 1);  // fill count
    localparam int unsigned CW = HW + 3;                 // bit cursor

    t_state r_state, n_state;

    // persistent stream state
    logic [HW-1:0] r_held;
    logic [CW-1:0] r_cursor;

    // per-transaction working registers
    logic [AW-1:0] r_addr;
    logic [3:0]    r_left;      // bytes still to be addressed
    logic          r_pend;      // read data returns this cycle
    logic [2:0]    r_align;
    logic [6:0]    r_cnt;
    logic          r_ext;       // result comes from the assembler
    logic          r_status;

    // output register
    logic                      r_ovalid;
    logic [MAX_FIELD_BITS-1:0] r_odata;
    logic                      r_ostat;

    // incoming transaction decode
    t_op        op;
    logic [7:0] byte_in;
    logic [6:0] cnt_raw;
    logic [6:0] cnt;
    logic       accept;
    logic       is_field;
    logic       has_room;
    logic [CW-1:0] avail;
    logic       too_short;
    logic       begin_fetch;
    logic [6:0] span_end;       // bit offset within first byte + count
    logic [7:0] span_round;
    logic       out_free;

    // RAM and assembler hookup
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_rdata;
    t_asm_ctl      asm_ctl;
    logic [MAX_FIELD_BITS-1:0] asm_value;

    assign op       = t_op'(i_s_tuser);
    assign byte_in  = i_s_tdata[7:0];
    assign cnt_raw  = i_s_tdata[14:8];
    assign cnt      = (cnt_raw > 7'(MAX_FIELD_BITS)) ? 7'(MAX_FIELD_BITS) : cnt_raw;
    assign accept   = i_s_tvalid && o_s_tready;
    assign is_field = (op == OP_PEEK) || (op == OP_READ);
    assign has_room = r_held < HW'(BUF_BYTES);
    // cursor never passes the filled bits, so this does not wrap
    assign avail    = {r_held, 3'b000} - r_cursor;
    assign too_short = CW'(cnt) > avail;
    assign begin_fetch = accept && is_field && !too_short && (cnt != 7'd0);
    assign span_end   = {4'd0, r_cursor[2:0]} + cnt;
    assign span_round = {1'b0, span_end} + 8'd7;
    assign out_free   = !r_ovalid || i_m_tready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = begin_fetch ? S_FETCH : S_DONE;
                end
            end
            S_FETCH: begin
                if (r_left == 4'd1) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_s_tready = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = r_addr;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                ram_addr   = r_held[AW-1:0];
                ram_we     = accept && (op == OP_APPEND) && has_room;
            end
            S_FETCH: begin
                ram_addr = r_addr;
            end
            S_DRAIN: begin
                ram_addr = r_addr;
            end
            S_DONE: begin
                ram_addr = r_addr;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    assign asm_ctl.clr      = accept;
    assign asm_ctl.shift_en = r_pend;
    assign asm_ctl.align    = r_align;
    assign asm_ctl.count    = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_held   <= '0;
            r_cursor <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= (r_state == S_FETCH);

            if (accept) begin
                if (ram_we) begin
                    r_held <= r_held + HW'(1);
                end
                if (begin_fetch && (op == OP_READ)) begin
                    r_cursor <= r_cursor + CW'(cnt);
                end
            end

            if ((r_state == S_DONE) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload and working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr   <= r_cursor[AW+2:3];
            r_left   <= span_round[6:3];
            r_align  <= 3'(~span_end[2:0] + 3'd1);
            r_cnt    <= cnt;
            r_ext    <= begin_fetch;
            r_status <= ((op == OP_APPEND) && !has_room) || (is_field && too_short);
        end else if (r_state == S_FETCH) begin
            r_addr <= r_addr + AW'(1);
            r_left <= r_left - 4'd1;
        end

        if ((r_state == S_DONE) && out_free) begin
            r_odata <= r_ext ? asm_value : '0;
            r_ostat <= r_status;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ostat;

    mfbr_ram #(
        .WIDTH (8),
        .DEPTH (BUF_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (byte_in),
        .o_rdata (ram_rdata)
    );

    mfbr_asm u_asm (
        .i_clk   (i_clk),
        .i_ctl   (asm_ctl),
        .i_byte  (ram_rdata),
        .o_value (asm_value)
    );

    // fill count stays within the buffer
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= HW'(BUF_BYTES))
        else $error("fill count beyond buffer size");

    // cursor never passes the last filled bit
    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= {r_held, 3'b000})
        else $error("bit cursor beyond filled bits");

    // a field never spans more than nine bytes
    a_fetch_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |-> (r_left != 4'd0) && (r_left <= 4'd9))
        else $error("fetch length out of range");

    // a failed transaction carries a zero field
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == '0))
        else $error("nonzero field on failed transaction");

    // reading stops once the last byte is addressed
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) && (r_left == 4'd1) |=> (r_state == S_DRAIN))
        else $error("fetch did not end after last byte");

endmodule
